// ===== hw/rtl/tlbft_pkg.sv =====
// ---------------------------------------------------------------------------
// tlbft_pkg
// Shared constants, types and control structs for the FIFO TLB page
// translation block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlbft_pkg;

    // geometry
    localparam int TLB_ENTRIES = 16;
    localparam int OFFSET_BITS = 8;
    localparam int PAGE_BITS   = 8;

    // field widths
    localparam int VA_W  = 16;
    localparam int PA_W  = 16;
    localparam int CNT_W = 16;

    // derived sizes
    localparam int PAGE_COUNT  = 1 << PAGE_BITS;
    localparam int TLB_IDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int FILL_W      = $clog2(TLB_ENTRIES + 1);
    localparam int FRAME_CNT_W = PAGE_BITS + 1;
    localparam int VA_EXT_W    = VA_W + OFFSET_BITS + PAGE_BITS;

    // stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = PA_W + 3 * CNT_W;
    localparam int OUT_TUSER_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // controller states
    typedef enum logic [0:0] {
        S_IDLE,
        S_RESOLVE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hw/rtl/tlbft_ctrl.sv =====
// ---------------------------------------------------------------------------
// tlbft_ctrl
// Two-state sequencer: take a word and start the page table read, then
// resolve the translation and commit it once the output register is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlbft_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  tlbft_pkg::t_dp_status i_status,
    output tlbft_pkg::t_ctrl_cmd  o_cmd
);

    tlbft_pkg::t_state r_state;
    tlbft_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlbft_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlbft_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tlbft_pkg::S_RESOLVE;
                end
            end
            tlbft_pkg::S_RESOLVE: begin
                if (i_status.out_free) begin
                    n_state = tlbft_pkg::S_IDLE;
                end
            end
            default: n_state = tlbft_pkg::S_IDLE;
        endcase
    end

    // outputs, input held off while in reset
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            tlbft_pkg::S_IDLE: begin
                o_in_ready    = i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
            end
            tlbft_pkg::S_RESOLVE: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tlbft_dp.sv =====
// ---------------------------------------------------------------------------
// tlbft_dp
// Translation datapath: TLB tag and frame registers with FIFO fill and
// replacement, page table memory with mapped bits, frame allocator,
// saturating counters and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlbft_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  tlbft_pkg::t_ctrl_cmd                 i_cmd,
    output tlbft_pkg::t_dp_status                o_status,
    input  wire [tlbft_pkg::VA_W-1:0]            i_va,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic [tlbft_pkg::OUT_TDATA_W-1:0]    o_out_data,
    output logic [tlbft_pkg::OUT_TUSER_W-1:0]    o_out_user
);

    localparam int N  = tlbft_pkg::TLB_ENTRIES;
    localparam int PB = tlbft_pkg::PAGE_BITS;
    localparam int OB = tlbft_pkg::OFFSET_BITS;

    // captured address and page table read data
    logic [tlbft_pkg::VA_W-1:0] r_va;
    logic [PB-1:0]              r_pt_rdata;

    // tlb storage
    logic [PB-1:0] r_tag   [N];
    logic [PB-1:0] r_frame [N];
    logic [N-1:0]  r_valid;
    logic [tlbft_pkg::FILL_W-1:0]    r_fill;
    logic [tlbft_pkg::TLB_IDX_W-1:0] r_oldest;

    // page table
    logic [PB-1:0]                     pt_mem [tlbft_pkg::PAGE_COUNT];
    logic [tlbft_pkg::PAGE_COUNT-1:0]  r_mapped;
    logic [tlbft_pkg::FRAME_CNT_W-1:0] r_next_frame;

    // counters
    logic [tlbft_pkg::CNT_W-1:0] r_hits;
    logic [tlbft_pkg::CNT_W-1:0] r_misses;
    logic [tlbft_pkg::CNT_W-1:0] r_faults;
    logic [tlbft_pkg::CNT_W-1:0] n_hits;
    logic [tlbft_pkg::CNT_W-1:0] n_misses;
    logic [tlbft_pkg::CNT_W-1:0] n_faults;

    // output register
    logic                                r_out_valid;
    logic [tlbft_pkg::OUT_TDATA_W-1:0]   r_out_data;
    logic [tlbft_pkg::OUT_TUSER_W-1:0]   r_out_user;

    // resolve logic
    logic [tlbft_pkg::VA_EXT_W-1:0] in_va_ext;
    logic [tlbft_pkg::VA_EXT_W-1:0] va_ext;
    logic [PB-1:0]                  in_page;
    logic [PB-1:0]                  page;
    logic [OB-1:0]                  offset;
    logic                           hit;
    logic [PB-1:0]                  hit_frame;
    logic                           fault;
    logic [PB-1:0]                  frame;
    logic [PB+OB-1:0]               pa_full;
    logic [tlbft_pkg::PA_W-1:0]     pa;
    logic                           tlb_full;
    logic [tlbft_pkg::TLB_IDX_W-1:0] slot;

    // address fields
    assign in_va_ext = tlbft_pkg::VA_EXT_W'(i_va);
    assign in_page   = in_va_ext[OB +: PB];
    assign va_ext    = tlbft_pkg::VA_EXT_W'(r_va);
    assign page      = va_ext[OB +: PB];
    assign offset    = va_ext[OB-1:0];

    // parallel tag compare, lowest matching slot wins
    always_comb begin
        hit       = 1'b0;
        hit_frame = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == page)) begin
                hit       = 1'b1;
                hit_frame = r_frame[i];
            end
        end
    end

    // miss path: allocate a frame on an unmapped page
    assign fault = !hit && !r_mapped[page];
    always_comb begin
        if (hit) begin
            frame = hit_frame;
        end else if (fault) begin
            frame = r_next_frame[PB-1:0];
        end else begin
            frame = r_pt_rdata;
        end
    end

    assign pa_full = {frame, offset};
    assign pa      = tlbft_pkg::PA_W'(pa_full);

    // fifo slot choice
    assign tlb_full = (r_fill == tlbft_pkg::FILL_W'(N));
    assign slot     = tlb_full ? r_oldest : r_fill[tlbft_pkg::TLB_IDX_W-1:0];

    // saturating counter updates
    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        n_faults = r_faults;
        if (hit) begin
            if (r_hits != tlbft_pkg::CNT_MAX) begin
                n_hits = r_hits + 1'b1;
            end
        end else if (r_misses != tlbft_pkg::CNT_MAX) begin
            n_misses = r_misses + 1'b1;
        end
        if (fault && (r_faults != tlbft_pkg::CNT_MAX)) begin
            n_faults = r_faults + 1'b1;
        end
    end

    // capture address
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_va <= i_va;
        end
    end

    // page table memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pt_rdata <= pt_mem[in_page];
        end
        if (i_cmd.commit && fault) begin
            pt_mem[page] <= frame;
        end
    end

    // tlb payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !hit) begin
            r_tag[slot]   <= page;
            r_frame[slot] <= frame;
        end
    end

    // control state: valid bits, mapped bits, fifo pointers, allocator, counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_fill       <= '0;
            r_oldest     <= '0;
            r_mapped     <= '0;
            r_next_frame <= '0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_faults     <= '0;
        end else if (i_cmd.commit) begin
            r_hits   <= n_hits;
            r_misses <= n_misses;
            r_faults <= n_faults;
            if (!hit) begin
                r_valid[slot] <= 1'b1;
                if (tlb_full) begin
                    if (r_oldest == tlbft_pkg::TLB_IDX_W'(N - 1)) begin
                        r_oldest <= '0;
                    end else begin
                        r_oldest <= r_oldest + 1'b1;
                    end
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (fault) begin
                r_mapped[page] <= 1'b1;
                if (r_next_frame < tlbft_pkg::FRAME_CNT_W'(tlbft_pkg::PAGE_COUNT)) begin
                    r_next_frame <= r_next_frame + 1'b1;
                end
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= {n_faults, n_misses, n_hits, pa};
            r_out_user <= {fault, hit};
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_out_user        = r_out_user;

endmodule

`default_nettype wire

// ===== hw/rtl/tlb_fifo_page_translation.sv =====
// ---------------------------------------------------------------------------
// tlb_fifo_page_translation
// Virtual to physical translation behind a 16-entry FIFO TLB with a
// 256-entry page table and sequential frame allocation on page faults.
//
// Usage:
//   Slave stream takes one virtual address per word (page in bits 15..8,
//   offset in bits 7..0). Master stream returns one word per address:
//   physical address and running hit, miss and fault counts in tdata, TLB
//   hit and page fault flags in tuser.
//   Each address is first captured while the page table memory is read
//   (synchronous read port); the block then compares all TLB tags in parallel,
//   picks the frame and updates TLB, page table and counters. The result is
//   registered in the output register, which drives m_axis_tvalid. A new
//   address is taken only once the previous one has been committed.
//   The next address is taken while a result still waits in the output
//   register; if the receiver stalls, the block holds the resolved word
//   until the output register frees up, and s_axis_tready stays low.
//   Reset clears the TLB valid bits, the page mapped bits, the FIFO pointers,
//   the frame allocator and the counters directly; no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlb_fifo_page_translation (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // slave stream
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire [tlbft_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [15:0] virtual_address
    // master stream
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [15:0] physical_address, [31:16] hit_count, [47:32] miss_count,
    // [63:48] fault_count
    output logic [tlbft_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [tlbft_pkg::OUT_TUSER_W-1:0]   m_axis_tuser   // [0] tlb_hit, [1] page_fault
);

    tlbft_pkg::t_ctrl_cmd  cmd;
    tlbft_pkg::t_dp_status status;

    // sequencer
    tlbft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // translation datapath
    tlbft_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_va        (s_axis_tdata[tlbft_pkg::VA_W-1:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

`default_nettype wire
